FILE: rtl/dvmb_pkg.sv
// Shared types and constants for the 2x2 depth binning unit.
// No dependencies.
package dvmb_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PSUM_W   = 17;
    localparam int PCNT_W   = 2;
    localparam int LINE_W   = PSUM_W + PCNT_W;
    localparam int TOTAL_W  = 18;
    localparam int COUNT_W  = 3;
    localparam int POS_W    = 10;
    localparam int DIM_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // x / 3 == (x * DIV3_MULT) >> DIV3_SHIFT for every x below 2**18
    localparam int DIV3_MULT_W = 18;
    localparam int DIV3_SHIFT  = 19;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT = 18'd174763;
    localparam int PROD_W = TOTAL_W + DIV3_MULT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MEAN,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/dvmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvmb_ram #(
    parameter int DATA_W = 19,
    parameter int DEPTH  = 512
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                         wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/dvmb_mean.sv
// Two-stage mean of up to four samples: total / count, count in 0..4.
// Depends on dvmb_pkg.
module dvmb_mean (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dvmb_pkg::TOTAL_W-1:0]  total,
    input  logic [dvmb_pkg::COUNT_W-1:0]  count,
    output logic                          done,
    output logic [dvmb_pkg::SAMPLE_W-1:0] mean
);
    import dvmb_pkg::*;

    logic                v1_reg;
    logic [TOTAL_W-1:0]  total1_reg;
    logic [COUNT_W-1:0]  count1_reg;
    logic                v2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [TOTAL_W-1:0]  total2_reg;
    logic [COUNT_W-1:0]  count2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        total1_reg <= total;
        count1_reg <= count;
        prod_reg   <= PROD_W'(total1_reg) * PROD_W'(DIV3_MULT);
        total2_reg <= total1_reg;
        count2_reg <= count1_reg;
    end

    always_comb
    begin
        case (count2_reg)
            3'd1:    mean = total2_reg[SAMPLE_W-1:0];
            3'd2:    mean = total2_reg[SAMPLE_W:1];
            3'd3:    mean = prod_reg[DIV3_SHIFT+SAMPLE_W-1:DIV3_SHIFT];
            3'd4:    mean = total2_reg[SAMPLE_W+1:2];
            default: mean = '0;
        endcase
    end

    assign done = v2_reg;

endmodule

FILE: rtl/depth_valid_mean_bin_2x2_unit.sv
// Top level of the 2x2 depth binning unit (zero samples ignored in bin means).
// Depends on dvmb_pkg, dvmb_ram and dvmb_mean.
//
// Usage:
//   s_axis carries depth pixels in raster order; tuser marks the first pixel
//   of a frame. m_axis carries result pixels; tlast marks the frame's last.
//   cfg writes bin_enable (0), frame_width (1), frame_height (2) while idle.
//   With binning on and a BIN_WIDTH x BIN_HEIGHT frame, even-row pairs are
//   summed into the line store; each odd-row, odd-column pixel reads its
//   entry back and yields the mean of the block's nonzero samples.
//   Otherwise each pixel passes straight through.
// Flow (one pixel in flight, gated by the line store read and the
// two-stage divide-by-count unit):
//   pixels that give no result: the unit stays idle, ready for the next;
//   pass-through pixel: EMIT loads it into the output register;
//   binned output pixel: READ, then MEAN until the mean is done, then EMIT.
// A finished result sits in the output register while the next pixel is
// taken; a stalled m_axis holds the result and stops input only once the
// next result is ready.
// Reset clears counters, config registers (to 0/640/480) and the output valid;
// the line store is not cleared and is filled by the even rows.
module depth_valid_mean_bin_2x2_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int BIN_WIDTH  = 640,
    parameter int BIN_HEIGHT = 480
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dvmb_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] depth_sample
    input  logic                            s_axis_tuser,  // [0] frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dvmb_pkg::SAMPLE_W-1:0]   m_axis_tdata,  // [15:0] out_sample
    output logic                            m_axis_tlast,  // frame_last
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dvmb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dvmb_pkg::DIM_W-1:0]      cfg_data
);
    import dvmb_pkg::*;

    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic               bin_enable_reg;
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   col_reg, row_reg;
    logic [SAMPLE_W-1:0] left_reg;
    logic [PSUM_W-1:0]  psum_reg;
    logic [PCNT_W-1:0]  pcnt_reg;
    logic [SAMPLE_W-1:0] result_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic               out_last_reg;

    logic               in_xfer;
    logic [POS_W-1:0]   col_cur, row_cur;
    logic               binning, col_end, row_end, odd_col, odd_row;
    logic [PSUM_W-1:0]  psum;
    logic [PCNT_W-1:0]  pcnt;
    logic [ADDR_W-1:0]  line_addr;
    logic               ram_wr_en, ram_rd_en;
    logic [LINE_W-1:0]  ram_rd_data;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
    logic               mean_start, mean_done;
    logic [SAMPLE_W-1:0] mean;
    logic               out_load;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_enable_reg   <= 1'b0;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BIN_ENABLE:   bin_enable_reg   <= cfg_data[0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // pixel position and decode
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign col_cur = s_axis_tuser ? '0 : col_reg;
    assign row_cur = s_axis_tuser ? '0 : row_reg;
    assign col_end = (DIM_W'(col_cur) + DIM_W'(1)) == frame_width_reg;
    assign row_end = (DIM_W'(row_cur) + DIM_W'(1)) == frame_height_reg;
    assign odd_col = col_cur[0];
    assign odd_row = row_cur[0];
    assign binning = bin_enable_reg
                     && (32'(frame_width_reg) == BIN_WIDTH)
                     && (32'(frame_height_reg) == BIN_HEIGHT);

    assign psum      = PSUM_W'(left_reg) + PSUM_W'(s_axis_tdata);
    assign pcnt      = PCNT_W'(left_reg != '0) + PCNT_W'(s_axis_tdata != '0);
    assign line_addr = ADDR_W'(col_cur[POS_W-1:1]);

    assign ram_wr_en = in_xfer && binning && odd_col && !odd_row;
    assign ram_rd_en = in_xfer && binning && odd_col && odd_row;

    dvmb_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (line_addr),
        .wr_data ({pcnt, psum}),
        .rd_en   (ram_rd_en),
        .rd_addr (line_addr),
        .rd_data (ram_rd_data)
    );

    // block total from this row's pair and the stored even-row pair
    assign total = TOTAL_W'(psum_reg) + TOTAL_W'(ram_rd_data[PSUM_W-1:0]);
    assign count = COUNT_W'(pcnt_reg) + COUNT_W'(ram_rd_data[LINE_W-1:PSUM_W]);
    assign mean_start = (state_reg == ST_READ);

    dvmb_mean u_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mean_start),
        .total (total),
        .count (count),
        .done  (mean_done),
        .mean  (mean)
    );

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!binning)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (odd_col && odd_row)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (mean_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                if (binning && !odd_col)
                begin
                    left_reg <= s_axis_tdata;
                end
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_cur + POS_W'(1);
                end
                else
                begin
                    col_reg <= col_cur + POS_W'(1);
                    row_reg <= row_cur;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            psum_reg   <= psum;
            pcnt_reg   <= pcnt;
            last_reg   <= col_end && row_end;
            result_reg <= s_axis_tdata;
        end
        else if ((state_reg == ST_MEAN) && mean_done)
        begin
            result_reg <= mean;
        end
        if (out_load)
        begin
            out_data_reg <= result_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_mean_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mean_done |-> (state_reg == ST_MEAN))
        else $error("mean result outside wait state");

    a_read_then_mean: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |=> (state_reg == ST_READ) ##1 (state_reg == ST_MEAN))
        else $error("line read not followed by mean");

    a_no_line_access_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en || ram_rd_en) |-> (state_reg == ST_IDLE))
        else $error("line store access while busy");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid && (state_reg == ST_IDLE))
        else $error("loaded result not presented");

endmodule
